[hw/rtl/rtrd_pkg.sv]
// shared types, constants and the arctangent table of the target record decoder
package rtrd_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ITER,
        ST_DONE
    } ctrl_state_t;

    localparam logic [1:0]  KIND_IGNORED   = 2'd0;
    localparam logic [1:0]  KIND_TARGET    = 2'd1;
    localparam logic [1:0]  KIND_FRAME_END = 2'd2;

    localparam logic [11:0] PKT_LEN        = 12'd14;
    localparam logic [15:0] TRAILER_OK     = 16'h5555;
    localparam logic [7:0]  MSG_GROUP      = 8'h06;
    localparam logic [7:0]  MSG_TARGET     = 8'h0b;
    localparam logic [7:0]  MSG_FRAME_END  = 8'h0a;

    localparam int SQ_W        = 26;
    localparam int SQRT_STEPS  = 13;
    localparam int CORDIC_W    = 25;
    localparam int ANGLE_W     = 18;
    localparam int TAB_LEN     = 24;
    localparam int ITER_W      = 5;

    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 18'sd16384;

    typedef struct packed {
        logic              load;
        logic              sq_en;
        logic [1:0]        sq_sel;
        logic              iter_en;
        logic [ITER_W-1:0] iter_idx;
        logic              publish;
    } dp_cmd_t;

    typedef struct packed {
        logic is_target;
    } dp_status_t;

    // atan(2^-i) in binary angle units, 32768 = pi
    function automatic logic [13:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic [13:0] val;
        unique case (idx)
            5'd0:    val = 14'd8192;
            5'd1:    val = 14'd4836;
            5'd2:    val = 14'd2555;
            5'd3:    val = 14'd1297;
            5'd4:    val = 14'd651;
            5'd5:    val = 14'd326;
            5'd6:    val = 14'd163;
            5'd7:    val = 14'd81;
            5'd8:    val = 14'd41;
            5'd9:    val = 14'd20;
            5'd10:   val = 14'd10;
            5'd11:   val = 14'd5;
            5'd12:   val = 14'd3;
            5'd13:   val = 14'd1;
            5'd14:   val = 14'd1;
            default: val = 14'd0;
        endcase
        return val;
    endfunction

endpackage

[hw/rtl/rtrd_ctrl.sv]
// sequencer of the target record decoder: handshakes, step counters, datapath commands
module rtrd_ctrl
    import rtrd_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam int NSTEPS = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
    localparam int NITER  = (NSTEPS > SQRT_STEPS) ? NSTEPS : SQRT_STEPS;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(NITER - 1);

    ctrl_state_t       state_reg, state_next;
    logic [1:0]        sq_cnt_reg, sq_cnt_next;
    logic [ITER_W-1:0] it_cnt_reg, it_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sq_cnt_reg    <= '0;
            it_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sq_cnt_reg    <= sq_cnt_next;
            it_cnt_reg    <= it_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next  = state_reg;
        sq_cnt_next = sq_cnt_reg;
        it_cnt_next = it_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                sq_cnt_next = '0;
                it_cnt_next = '0;
                if (in_valid)
                begin
                    state_next = status.is_target ? ST_SQUARE : ST_DONE;
                end
            end
            ST_SQUARE:
            begin
                sq_cnt_next = sq_cnt_reg + 2'd1;
                if (sq_cnt_reg == 2'd3)
                begin
                    state_next = ST_ITER;
                end
            end
            ST_ITER:
            begin
                it_cnt_next = it_cnt_reg + 1'b1;
                if (it_cnt_reg == ITER_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        in_stall     = 1'b1;
        cmd.sq_sel   = sq_cnt_reg;
        cmd.iter_idx = it_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_SQUARE:
            begin
                cmd.sq_en = 1'b1;
            end
            ST_ITER:
            begin
                cmd.iter_en = 1'b1;
            end
            ST_DONE:
            begin
                cmd.publish = slot_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in work");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || !out_stall))
        else $error("result overwrote a stalled transfer");

    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ITER |-> it_cnt_reg <= ITER_LAST)
        else $error("iteration count out of range");

endmodule

[hw/rtl/rtrd_datapath.sv]
// field decode, squares, two integer square roots, cordic atan2, target counter, result register
module rtrd_datapath
    import rtrd_pkg::*;
#(
    parameter int COUNT_MAX    = 255,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic [11:0]        packet_length,
    input  logic [7:0]         msg_low,
    input  logic [7:0]         msg_high,
    input  logic [7:0]         target_id,
    input  logic [47:0]        payload,
    input  logic [15:0]        trailer,
    output logic [1:0]         kind,
    output logic [7:0]         object_index,
    output logic signed [13:0] pos_forward,
    output logic signed [10:0] pos_left,
    output logic signed [9:0]  vel_forward,
    output logic signed [9:0]  vel_left,
    output logic [12:0]        range_dist,
    output logic [9:0]         speed,
    output logic signed [15:0] azimuth,
    output logic [7:0]         frame_targets
);

    localparam int NSTEPS = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
    localparam logic [ITER_W-1:0] CORDIC_END = ITER_W'(NSTEPS);
    localparam logic [ITER_W-1:0] SQRT_END   = ITER_W'(SQRT_STEPS);
    localparam logic [7:0] LIMIT = (COUNT_MAX > 255) ? 8'd255 : 8'(COUNT_MAX);
    localparam logic [SQ_W-1:0] SQRT_BIT0 = SQ_W'(1) << (2 * (SQRT_STEPS - 1));

    // decode
    logic              frame_ok, is_target, is_frame_end;
    logic signed [13:0] pf_in;
    logic signed [11:0] pl_wide;
    logic signed [10:0] pl_in;
    logic signed [10:0] vf_wide;
    logic signed [9:0]  vf_in, vl_in;

    assign frame_ok     = (packet_length == PKT_LEN) && (trailer == TRAILER_OK)
                          && (msg_high == MSG_GROUP);
    assign is_target    = frame_ok && (msg_low == MSG_TARGET);
    assign is_frame_end = frame_ok && (msg_low == MSG_FRAME_END);
    assign status.is_target = is_target;

    assign pf_in   = $signed({1'b0, payload[47:35]}) - 14'sd5000;
    assign pl_wide = 12'sd1023 - $signed({1'b0, payload[34:24]});
    assign pl_in   = pl_wide[10:0];
    assign vf_wide = $signed({1'b0, payload[23:14]}) - 11'sd512;
    assign vf_in   = vf_wide[9:0];
    assign vl_in   = 10'sd256 - $signed({1'b0, payload[13:5]});

    // cordic start vector with quadrant fold
    logic signed [CORDIC_W-1:0] x_scaled, y_scaled, x_start, y_start;
    logic signed [ANGLE_W-1:0]  z_start;

    assign x_scaled = {{(CORDIC_W-22){pf_in[13]}}, pf_in, 8'b0};
    assign y_scaled = {{(CORDIC_W-19){pl_in[10]}}, pl_in, 8'b0};

    always_comb
    begin
        x_start = x_scaled;
        y_start = y_scaled;
        z_start = '0;
        if (x_scaled < 0)
        begin
            if (y_scaled >= 0)
            begin
                x_start = y_scaled;
                y_start = -x_scaled;
                z_start = QUARTER_TURN;
            end
            else
            begin
                x_start = -y_scaled;
                y_start = x_scaled;
                z_start = -QUARTER_TURN;
            end
        end
    end

    // working registers
    logic [1:0]         kind_reg;
    logic [7:0]         index_reg, frame_reg, count_reg;
    logic signed [13:0] pf_reg;
    logic signed [10:0] pl_reg;
    logic signed [9:0]  vf_reg, vl_reg;
    logic               zero_vec_reg;
    logic [SQ_W-1:0]    sq_r_reg, sq_s_reg, res_r_reg, res_s_reg, bit_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg;
    logic signed [ANGLE_W-1:0]  z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (is_frame_end)
            begin
                count_reg <= '0;
            end
            else if (is_target && (count_reg < LIMIT))
            begin
                count_reg <= count_reg + 8'd1;
            end
        end
    end

    // one square per cycle through a shared multiplier
    logic signed [13:0] mul_op;
    logic signed [27:0] mul_prod;
    logic [SQ_W-1:0]    prod_cut;

    always_comb
    begin
        unique case (cmd.sq_sel)
            2'd0:    mul_op = pf_reg;
            2'd1:    mul_op = 14'(pl_reg);
            2'd2:    mul_op = 14'(vf_reg);
            default: mul_op = 14'(vl_reg);
        endcase
    end

    assign mul_prod = mul_op * mul_op;
    assign prod_cut = mul_prod[SQ_W-1:0];

    // square root steps, remainder kept in the square accumulators
    logic [SQ_W-1:0] trial_r, trial_s;
    logic            sqrt_en, cordic_en;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [ANGLE_W-1:0]  dz;

    assign trial_r   = res_r_reg + bit_reg;
    assign trial_s   = res_s_reg + bit_reg;
    assign sqrt_en   = cmd.iter_en && (cmd.iter_idx < SQRT_END);
    assign cordic_en = cmd.iter_en && (cmd.iter_idx < CORDIC_END) && !zero_vec_reg;
    assign dx        = y_reg >>> cmd.iter_idx;
    assign dy        = x_reg >>> cmd.iter_idx;
    assign dz        = ANGLE_W'($signed({1'b0, atan_entry(cmd.iter_idx)}));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg     <= is_target ? KIND_TARGET
                          : (is_frame_end ? KIND_FRAME_END : KIND_IGNORED);
            index_reg    <= is_target ? target_id : 8'd0;
            frame_reg    <= is_frame_end ? count_reg : 8'd0;
            pf_reg       <= is_target ? pf_in : 14'sd0;
            pl_reg       <= is_target ? pl_in : 11'sd0;
            vf_reg       <= is_target ? vf_in : 10'sd0;
            vl_reg       <= is_target ? vl_in : 10'sd0;
            zero_vec_reg <= (pf_in == 14'sd0) && (pl_in == 11'sd0);
            x_reg        <= x_start;
            y_reg        <= y_start;
            z_reg        <= is_target ? z_start : '0;
            res_r_reg    <= '0;
            res_s_reg    <= '0;
            sq_r_reg     <= '0;
            sq_s_reg     <= '0;
            bit_reg      <= SQRT_BIT0;
        end
        if (cmd.sq_en)
        begin
            unique case (cmd.sq_sel)
                2'd0:    sq_r_reg <= prod_cut;
                2'd1:    sq_r_reg <= sq_r_reg + prod_cut;
                2'd2:    sq_s_reg <= prod_cut;
                default: sq_s_reg <= sq_s_reg + prod_cut;
            endcase
        end
        if (sqrt_en)
        begin
            bit_reg <= bit_reg >> 2;
            if (sq_r_reg >= trial_r)
            begin
                sq_r_reg  <= sq_r_reg - trial_r;
                res_r_reg <= (res_r_reg >> 1) + bit_reg;
            end
            else
            begin
                res_r_reg <= res_r_reg >> 1;
            end
            if (sq_s_reg >= trial_s)
            begin
                sq_s_reg  <= sq_s_reg - trial_s;
                res_s_reg <= (res_s_reg >> 1) + bit_reg;
            end
            else
            begin
                res_s_reg <= res_s_reg >> 1;
            end
        end
        if (cordic_en)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + dz;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - dz;
            end
        end
    end

    // result register, loaded on the transfer into the output slot
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            kind          <= kind_reg;
            object_index  <= index_reg;
            pos_forward   <= pf_reg;
            pos_left      <= pl_reg;
            vel_forward   <= vf_reg;
            vel_left      <= vl_reg;
            range_dist    <= res_r_reg[12:0];
            speed         <= res_s_reg[9:0];
            azimuth       <= z_reg[15:0];
            frame_targets <= frame_reg;
        end
    end

endmodule

[hw/rtl/radar_target_record_decoder_core.sv]
// top level of the radar target record decoder
// usage:
//   input channel (in_valid / in_stall) takes one 14-byte packet summary per transfer;
//   output channel (out_valid / out_stall) gives one result per packet, in order.
//   packets with wrong length, trailer or message id give kind 0 with zero fields.
//   a target record gives positions, velocities, floored range and speed and an
//   atan2 azimuth; a frame end gives the target count and clears it.
// sequence:
//   target record: accept, 4 square steps (one shared multiplier), then
//   max(13, CORDIC_STEPS capped at 24) root/cordic steps, then the output
//   transfer; other packets go from the accept straight to the output transfer.
//   the block works on one packet at a time; the next packet is taken as soon
//   as the result has moved into the output register.
// stall: a stalled result holds in the output register; the finished next
//   result waits in the datapath until the output slot frees.
// reset: clears the sequencer, the output valid and the target count.
module radar_target_record_decoder_core
    import rtrd_pkg::*;
#(
    parameter int COUNT_MAX    = 255,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [11:0]        packet_length,
    input  logic [7:0]         msg_low,
    input  logic [7:0]         msg_high,
    input  logic [7:0]         target_id,
    input  logic [47:0]        payload,
    input  logic [15:0]        trailer,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [7:0]         object_index,
    output logic signed [13:0] pos_forward,
    output logic signed [10:0] pos_left,
    output logic signed [9:0]  vel_forward,
    output logic signed [9:0]  vel_left,
    output logic [12:0]        range_dist,
    output logic [9:0]         speed,
    output logic signed [15:0] azimuth,
    output logic [7:0]         frame_targets
);

    dp_cmd_t    cmd;
    dp_status_t status;

    rtrd_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    rtrd_datapath #(
        .COUNT_MAX   (COUNT_MAX),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .packet_length (packet_length),
        .msg_low       (msg_low),
        .msg_high      (msg_high),
        .target_id     (target_id),
        .payload       (payload),
        .trailer       (trailer),
        .kind          (kind),
        .object_index  (object_index),
        .pos_forward   (pos_forward),
        .pos_left      (pos_left),
        .vel_forward   (vel_forward),
        .vel_left      (vel_left),
        .range_dist    (range_dist),
        .speed         (speed),
        .azimuth       (azimuth),
        .frame_targets (frame_targets)
    );

endmodule
